// ===== rtl/tmrb_pkg.sv =====
// Shared constants and types for the tilemap rectangle blit address generator.
package tmrb_pkg;

  localparam int unsigned WordW      = 16;
  localparam int unsigned AddrW      = 16;
  localparam int unsigned OffsetW    = 11;
  localparam int unsigned ColW       = 5;
  localparam int unsigned RowW       = 5;
  localparam int unsigned CountW     = 8;
  localparam int unsigned CfgIndexW  = 3;
  localparam int unsigned CfgDataW   = 8;

  // Plane bases share the top nibble; bit 11 selects between them.
  localparam logic [3:0]           PlaneBaseNibble = 4'h9;
  localparam logic [OffsetW-1:0]   RowStep         = 11'h040;
  localparam logic [5:0]           ColStep         = 6'd2;
  localparam logic [WordW-1:0]     FlipMask        = 16'h8000;

  typedef enum logic [CfgIndexW-1:0] {
    REG_PLANE_SELECT = 3'd0,
    REG_START_COLUMN = 3'd1,
    REG_START_ROW    = 3'd2,
    REG_RECT_WIDTH   = 3'd3,
    REG_RECT_HEIGHT  = 3'd4,
    REG_MIRROR_MODE  = 3'd5
  } cfg_reg_t;

endpackage

// ===== rtl/tilemap_rect_blit_address_gen_unit.sv =====
// Top level of the tilemap rectangle blit address generator.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------------------------------
//   in_     | input     | in_valid / in_ready  | in_tile_word[15:0]
//   out_    | output    | out_valid / out_ready| out_write_address, out_write_word,
//           |           |                      | out_last_write
//   cfg_    | input     | cfg_valid / cfg_ready| cfg_index[2:0], cfg_data[7:0]
//
// Each word is turned into a write by registering it: the address walker and the output
// register sit back to back, so one word is taken per cycle under no stall.
// A word is accepted whenever the output register is empty or being drained.
// rst_n is synchronous; it empties the output register, rearms the origin and
// restores the register defaults. Words arriving with a zero width or height
// are taken and dropped. cfg_ready is always high.
module tilemap_rect_blit_address_gen_unit
  import tmrb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [WordW-1:0]     in_tile_word,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [AddrW-1:0]     out_write_address,
  output logic [WordW-1:0]     out_write_word,
  output logic                 out_last_write,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [CfgDataW-1:0]  cfg_data
);

  // Configuration registers
  logic               plane_select_r;
  logic [ColW-1:0]    start_column_r;
  logic [RowW-1:0]    start_row_r;
  logic [CountW-1:0]  rect_width_r;
  logic [CountW-1:0]  rect_height_r;
  logic               mirror_mode_r;

  // Walker state
  logic               in_progress_r, in_progress_nxt;
  logic [OffsetW-1:0] row_offset_r, row_offset_nxt;
  logic [OffsetW-1:0] column_offset_r, column_offset_nxt;
  logic [CountW-1:0]  rows_done_r, rows_done_nxt;
  logic [CountW-1:0]  columns_done_r, columns_done_nxt;

  // Output register
  logic               out_valid_r, out_valid_nxt;
  logic [AddrW-1:0]   out_addr_r;
  logic [WordW-1:0]   out_word_r;
  logic               out_last_r;

  logic               in_fire;
  logic               cfg_fire;
  logic               cfg_hit;
  logic               rect_empty;
  logic               emit;
  logic [ColW-1:0]    origin_col;
  logic [OffsetW-1:0] origin;
  logic [OffsetW-1:0] cur_row;
  logic [OffsetW-1:0] cur_col;
  logic [CountW-1:0]  cur_rows;
  logic [CountW-1:0]  cur_cols;
  logic [5:0]         col_low_nxt;
  logic [CountW-1:0]  cols_inc;
  logic [CountW-1:0]  rows_inc;
  logic [OffsetW-1:0] row_step_sum;
  logic               row_end;
  logic               rect_end;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign cfg_hit   = cfg_fire && (cfg_index < CfgIndexW'(REG_MIRROR_MODE + 3'd1));

  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;

  assign rect_empty = (rect_width_r == '0) || (rect_height_r == '0);
  assign emit       = in_fire && !rect_empty;

  // In mirror mode the walk starts at the right edge of the rectangle.
  assign origin_col = mirror_mode_r ? (start_column_r + rect_width_r[ColW-1:0] - ColW'(1))
                                    : start_column_r;
  assign origin     = {start_row_r, origin_col, 1'b0};

  assign cur_row  = in_progress_r ? row_offset_r    : origin;
  assign cur_col  = in_progress_r ? column_offset_r : origin;
  assign cur_rows = in_progress_r ? rows_done_r     : '0;
  assign cur_cols = in_progress_r ? columns_done_r  : '0;

  assign col_low_nxt  = mirror_mode_r ? (cur_col[5:0] - ColStep) : (cur_col[5:0] + ColStep);
  assign cols_inc     = cur_cols + CountW'(1);
  assign rows_inc     = cur_rows + CountW'(1);
  assign row_step_sum = cur_row + RowStep;
  assign row_end      = (cols_inc >= rect_width_r);
  assign rect_end     = row_end && (rows_inc >= rect_height_r);

  always_comb begin
    in_progress_nxt   = in_progress_r;
    row_offset_nxt    = row_offset_r;
    column_offset_nxt = column_offset_r;
    rows_done_nxt     = rows_done_r;
    columns_done_nxt  = columns_done_r;
    if (emit) begin
      in_progress_nxt = 1'b1;
      row_offset_nxt  = cur_row;
      rows_done_nxt   = cur_rows;
      if (row_end) begin
        columns_done_nxt  = '0;
        row_offset_nxt    = row_step_sum;
        column_offset_nxt = row_step_sum;
        rows_done_nxt     = rows_inc;
        if (rect_end) begin
          in_progress_nxt = 1'b0;
          rows_done_nxt   = '0;
        end
      end else begin
        columns_done_nxt  = cols_inc;
        column_offset_nxt = {cur_col[OffsetW-1:6], col_low_nxt};
      end
    end
    // Any register write restarts the rectangle from its origin.
    if (cfg_hit) begin
      in_progress_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plane_select_r  <= 1'b0;
      start_column_r  <= '0;
      start_row_r     <= '0;
      rect_width_r    <= CountW'(1);
      rect_height_r   <= CountW'(1);
      mirror_mode_r   <= 1'b0;
      in_progress_r   <= 1'b0;
      row_offset_r    <= '0;
      column_offset_r <= '0;
      rows_done_r     <= '0;
      columns_done_r  <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      in_progress_r   <= in_progress_nxt;
      row_offset_r    <= row_offset_nxt;
      column_offset_r <= column_offset_nxt;
      rows_done_r     <= rows_done_nxt;
      columns_done_r  <= columns_done_nxt;
      out_valid_r     <= out_valid_nxt;
      if (cfg_fire) begin
        unique case (cfg_index)
          REG_PLANE_SELECT: plane_select_r <= cfg_data[0];
          REG_START_COLUMN: start_column_r <= cfg_data[ColW-1:0];
          REG_START_ROW:    start_row_r    <= cfg_data[RowW-1:0];
          REG_RECT_WIDTH:   rect_width_r   <= cfg_data;
          REG_RECT_HEIGHT:  rect_height_r  <= cfg_data;
          REG_MIRROR_MODE:  mirror_mode_r  <= cfg_data[0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_addr_r <= {PlaneBaseNibble, plane_select_r, cur_col};
      out_word_r <= mirror_mode_r ? (in_tile_word ^ FlipMask) : in_tile_word;
      out_last_r <= rect_end;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_write_address = out_addr_r;
  assign out_write_word    = out_word_r;
  assign out_last_write    = out_last_r;

endmodule

// ===== rtl/tmrb_checker.sv =====
// Port-level assertions for the tilemap rectangle blit address generator and their bind.
module tmrb_checker
  import tmrb_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [AddrW-1:0]     out_write_address,
  input logic [WordW-1:0]     out_write_word,
  input logic                 out_last_write
);

  // Every write lands inside one of the two planes.
  a_addr_in_plane: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_write_address[15:12] == PlaneBaseNibble))
    else $error("write address outside the tile planes");

  // Tile words are two bytes, so addresses are always even.
  a_addr_even: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_write_address[0] == 1'b0))
    else $error("odd write address");

  // With the output register empty the block must take a new word.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled while output register empty");

  // Reset leaves no pending write.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("write pending after reset");

  // A stalled write holds its address, word and flag.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_write_address) && $stable(out_write_word)
       && $stable(out_last_write)))
    else $error("stalled write changed");

endmodule

bind tilemap_rect_blit_address_gen_unit tmrb_checker u_tmrb_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_write_address (out_write_address),
  .out_write_word    (out_write_word),
  .out_last_write    (out_last_write)
);
